FILE: design/sle_pkg.sv
// Shared types, codes and helpers for the sorted list engine.
// No dependencies; imported by sle_cell, sle_chain and sorted_list_engine_unit.
package sle_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           req_type;
      logic signed [VALUE_W-1:0] value;
   } req_type_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic                      cmp_en;
      logic                      ins_en;
      logic                      rem_en;
      logic signed [VALUE_W-1:0] key;
   } ctl_type;

   typedef struct packed {
      logic lt;
      logic le;
      logic eq;
   } flag_type;

   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] lt_cnt;
      logic [CNT_W-1:0] le_cnt;
   } chain_stat_type;

   function automatic logic [CNT_W-1:0] therm_count(input logic [DEPTH-1:0] t);
      logic [DEPTH+1:0] ext;
      logic [CNT_W-1:0] n;
      ext = {1'b0, t, 1'b1};
      n   = '0;
      for (int j = 0; j <= DEPTH; j++) begin
         if (ext[j] && !ext[j+1]) begin
            n = n | CNT_W'(j);
         end
      end
      return n;
   endfunction

endpackage

FILE: design/sorted_list_engine_unit.sv
// Sorted list engine: keeps up to DEPTH signed values in ascending order.
// Request beat (req_valid/req_ready, req_data): req_type 0 insert, 1 remove,
// 2 search, 3 no operation; value is the signed 32-bit key.
// Response beat (rsp_valid/rsp_ready, rsp_data): status (ok, not found,
// empty, full), 1-based position (0 unless ok) and occupancy afterwards.
// Every request gives exactly one response, in order.
// Each request passes through accept, compare and shift: in compare every cell
// compares its entry with the key; in shift the cells move toward or away
// from the key's slot and the response register loads. A new request is taken
// only once the previous one has left the compare-then-shift sequence.
// Response valid is registered and rises as the shift step completes.
// A stalled response holds in its register; the next request may be taken
// meanwhile and waits in the shift cycle until the register frees.
// Synchronous reset empties the list and drops any pending response.
// Depends on sle_pkg and sle_chain.
module sorted_list_engine_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sle_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sle_pkg::rsp_type      rsp_data
);
   import sle_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   req_type_type       req_ff;
   ctl_type            ctl;
   chain_stat_type     stat;
   logic               slot_free;
   logic               full;
   logic               empty;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   sle_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .count (count_ff),
      .stat  (stat)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl.cmp_en   = 1'b0;
      ctl.ins_en   = 1'b0;
      ctl.rem_en   = 1'b0;
      ctl.key      = req_ff.value;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctl.cmp_en = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            if (slot_free) begin
               rsp_in.status   = ST_OK;
               rsp_in.position = '0;
               unique case (req_ff.req_type)
                  OP_INSERT: begin
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctl.ins_en      = 1'b1;
                        rsp_in.position = POS_W'(stat.le_cnt) + POS_W'(1);
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (!stat.found) begin
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        ctl.rem_en      = 1'b1;
                        rsp_in.position = POS_W'(stat.lt_cnt) + POS_W'(1);
                        count_in        = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (!stat.found) begin
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        rsp_in.position = POS_W'(stat.lt_cnt) + POS_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.occupancy = POS_W'(count_in);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_accept_to_cmp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CMP))
      else $error("accepted request did not start compare");

   a_cmp_to_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |=> (state_ff == S_APPLY))
      else $error("compare not followed by shift cycle");

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_ff.occupancy == POS_W'(count_ff)))
      else $error("response occupancy differs from list count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPLY) |=> $stable(count_ff))
      else $error("count changed outside shift cycle");
`endif

endmodule

FILE: design/sle_cell.sv
// One storage cell of the sorted list: an entry plus its compare flags.
// Depends on sle_pkg.
module sle_cell (
   input  logic                              clock,
   input  sle_pkg::ctl_type                  ctl,
   input  logic                              occ,
   input  logic                              left_le,
   input  logic signed [sle_pkg::VALUE_W-1:0] left_value,
   input  logic signed [sle_pkg::VALUE_W-1:0] right_value,
   output sle_pkg::flag_type                 flags,
   output logic signed [sle_pkg::VALUE_W-1:0] value
);
   import sle_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   flag_type                  flags_ff;

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         flags_ff.lt <= occ && (entry_ff <  ctl.key);
         flags_ff.le <= occ && (entry_ff <= ctl.key);
         flags_ff.eq <= occ && (entry_ff == ctl.key);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ins_en && !flags_ff.le) begin
         entry_ff <= left_le ? ctl.key : left_value;
      end else if (ctl.rem_en && !flags_ff.lt) begin
         entry_ff <= right_value;
      end
   end

   assign flags = flags_ff;
   assign value = entry_ff;

endmodule

FILE: design/sle_chain.sv
// Row of DEPTH cells with neighbor links and thermometer-to-count encoders.
// Depends on sle_pkg and sle_cell.
module sle_chain (
   input  logic                         clock,
   input  sle_pkg::ctl_type             ctl,
   input  logic [sle_pkg::CNT_W-1:0]    count,
   output sle_pkg::chain_stat_type      stat
);
   import sle_pkg::*;

   flag_type                  flags [DEPTH];
   logic signed [VALUE_W-1:0] values [DEPTH];
   logic [DEPTH-1:0]          lt_vec;
   logic [DEPTH-1:0]          le_vec;
   logic [DEPTH-1:0]          eq_vec;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      occ;
      logic                      left_le;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      assign occ = (count > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_le    = 1'b1;
         assign left_value = ctl.key;
      end else begin : g_body
         assign left_le    = flags[i-1].le;
         assign left_value = values[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = values[i];
      end else begin : g_mid
         assign right_value = values[i+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occ         (occ),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .flags       (flags[i]),
         .value       (values[i])
      );

      assign lt_vec[i] = flags[i].lt;
      assign le_vec[i] = flags[i].le;
      assign eq_vec[i] = flags[i].eq;
   end

   assign stat.found  = |eq_vec;
   assign stat.lt_cnt = therm_count(lt_vec);
   assign stat.le_cnt = therm_count(le_vec);

endmodule
